// ===== rtl/pds_pkg.sv =====
package pds_pkg;

   localparam int DATA_W = 16;
   localparam int OCC_W = 5;

   localparam logic [DATA_W-1:0] RESET_TIME_SLICE = 16'd5;

   localparam logic [1:0] POLICY_FCFS = 2'd0;
   localparam logic [1:0] POLICY_SJF  = 2'd1;
   localparam logic [1:0] POLICY_RR   = 2'd2;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   localparam logic CSR_POLICY     = 1'b0;
   localparam logic CSR_TIME_SLICE = 1'b1;

   typedef enum logic [2:0] {
      CMD_ENQ,
      CMD_FCFS,
      CMD_SJF,
      CMD_RR,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      logic [DATA_W-1:0] run_length;
      logic [DATA_W-1:0] task_id;
      cmd_kind_type      kind;
   } cmd_type;

   typedef struct packed {
      logic [OCC_W-1:0]  occupancy;
      logic              rejected;
      logic              completed;
      logic [DATA_W-1:0] granted_time;
      logic [DATA_W-1:0] out_id;
      logic              dispatched;
   } rsp_type;

endpackage

// ===== rtl/pds_front.sv =====
module pds_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,
   input  logic [31:0]      req_tdata,
   input  logic [1:0]       policy,
   output logic             cmd_valid,
   output pds_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import pds_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    cls;
   logic       push;
   logic       pop;

   always_comb begin
      cls.task_id    = req_tdata[15:0];
      cls.run_length = req_tdata[31:16];
      if (req_tuser == REQ_ENQUEUE) begin
         cls.kind = CMD_ENQ;
      end else begin
         unique case (policy)
            POLICY_FCFS: cls.kind = CMD_FCFS;
            POLICY_SJF:  cls.kind = CMD_SJF;
            POLICY_RR:   cls.kind = CMD_RR;
            default:     cls.kind = CMD_NOP;
         endcase
      end
   end

   assign req_tready = (fill_ff != 2'd2);
   assign cmd_valid  = (fill_ff != 2'd0);
   assign cmd        = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/pds_back.sv =====
module pds_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      time_slice,
   input  logic             cmd_valid,
   input  pds_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata
);
   import pds_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W:0] DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_HEAD  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_SH_RD = 5'b01000,
      ST_SH_WR = 5'b10000
   } state_type;

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [OCC_W-1:0] occ(input logic [CNT_W-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[OCC_W-1:0];
   endfunction

   logic [31:0]       mem [QUEUE_DEPTH];
   logic [31:0]       rd_q_ff;
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_wa, mem_ra;
   logic [31:0]       mem_wd;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rr_ff, rr_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              dv_ff, dv_in;
   logic [CNT_W-1:0]  didx_ff, didx_in;
   logic [15:0]       min_ff, min_in;
   logic [15:0]       pid_ff, pid_in;
   logic [CNT_W-1:0]  pick_ff, pick_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              out_free;
   logic [15:0]       rd_id, rd_rem;
   logic              sel;
   logic [CNT_W-1:0]  pick_now;
   logic [15:0]       min_now, pid_now;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_id      = rd_q_ff[15:0];
   assign rd_rem     = rd_q_ff[31:16];

   always_comb begin
      sel      = dv_ff && ((didx_ff == '0) || (rd_rem < min_ff));
      pick_now = sel ? didx_ff : pick_ff;
      min_now  = sel ? rd_rem : min_ff;
      pid_now  = sel ? rd_id : pid_ff;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rr_in        = rr_ff;
      iss_in       = iss_ff;
      dv_in        = 1'b0;
      didx_in      = didx_ff;
      min_in       = min_ff;
      pid_in       = pid_ff;
      pick_in      = pick_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = phys(head_ff, count_ff);
      mem_wd       = {cmd.run_length, cmd.task_id};
      mem_re       = 1'b0;
      mem_ra       = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop          = 1'b1;
               rsp_in           = '0;
               rsp_in.occupancy = occ(count_ff);
               rsp_valid_in     = 1'b1;
               unique case (cmd.kind)
                  CMD_ENQ: begin
                     if (count_ff == DEPTH_CNT) begin
                        rsp_in.rejected = 1'b1;
                     end else begin
                        mem_we           = 1'b1;
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = occ(count_in);
                     end
                  end
                  CMD_FCFS, CMD_RR: begin
                     if (count_ff != '0) begin
                        mem_re       = 1'b1;
                        rr_in        = (cmd.kind == CMD_RR);
                        rsp_valid_in = 1'b0;
                        state_in     = ST_HEAD;
                     end
                  end
                  CMD_SJF: begin
                     if (count_ff != '0) begin
                        iss_in       = '0;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HEAD: begin
            head_in             = phys(head_ff, CNT_W'(1));
            rsp_in              = '0;
            rsp_in.dispatched   = 1'b1;
            rsp_in.out_id       = rd_id;
            rsp_valid_in        = 1'b1;
            if (rr_ff && (rd_rem > time_slice)) begin
               mem_we              = 1'b1;
               mem_wd              = {rd_rem - time_slice, rd_id};
               rsp_in.granted_time = time_slice;
               rsp_in.occupancy    = occ(count_ff);
            end else begin
               count_in            = count_ff - 1'b1;
               rsp_in.granted_time = rd_rem;
               rsp_in.completed    = 1'b1;
               rsp_in.occupancy    = occ(count_in);
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (iss_ff < count_ff) begin
               mem_re  = 1'b1;
               mem_ra  = phys(head_ff, iss_ff);
               iss_in  = iss_ff + 1'b1;
               dv_in   = 1'b1;
               didx_in = iss_ff;
            end
            min_in  = min_now;
            pid_in  = pid_now;
            pick_in = pick_now;
            if (dv_ff && (({1'b0, didx_ff} + 1'b1) == {1'b0, count_ff})) begin
               dv_in               = 1'b0;
               rsp_in              = '0;
               rsp_in.dispatched   = 1'b1;
               rsp_in.out_id       = pid_now;
               rsp_in.granted_time = min_now;
               rsp_in.completed    = 1'b1;
               rsp_in.occupancy    = occ(count_ff - 1'b1);
               rsp_valid_in        = 1'b1;
               j_in                = pick_now;
               if (({1'b0, pick_now} + 1'b1) < {1'b0, count_ff}) begin
                  state_in = ST_SH_RD;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SH_RD: begin
            mem_re   = 1'b1;
            mem_ra   = phys(head_ff, j_ff + 1'b1);
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            mem_we = 1'b1;
            mem_wa = phys(head_ff, j_ff);
            mem_wd = rd_q_ff;
            j_in   = j_ff + 1'b1;
            if (({1'b0, j_ff} + 2'd2) < {1'b0, count_ff}) begin
               state_in = ST_SH_RD;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff   <= rr_in;
      iss_ff  <= iss_in;
      didx_ff <= didx_in;
      min_ff  <= min_in;
      pid_ff  <= pid_in;
      pick_ff <= pick_in;
      j_ff    <= j_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_q_ff <= mem[mem_ra];
      end
   end

endmodule

// ===== rtl/process_dispatch_scheduler.sv =====
// enqueues and idle ticks are answered from the idle state, fcfs and round robin
// ticks through the head state; shortest job first scans every entry, then closes
// up the task memory by reading and writing each entry behind the pick in turn
// one enqueue per cycle while the result side is not stalled; other ticks hold
// off new commands until done; the input buffers 2 transfers, even while a result waits
// reset clears policy, time_slice to 5, task count and handshake state, not the memory
module process_dispatch_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // req_type
   input  logic [31:0] req_tdata,   // task_id, run_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // dispatched, out_id, granted_time, completed,
                                    // rejected, occupancy
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   import pds_pkg::*;

   logic [1:0]  policy_ff, policy_in;
   logic [15:0] time_slice_ff, time_slice_in;
   logic        cmd_valid;
   cmd_type     cmd;
   logic        cmd_pop;

   always_comb begin
      policy_in     = policy_ff;
      time_slice_in = time_slice_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_POLICY:     policy_in     = csr_wdata[1:0];
            CSR_TIME_SLICE: time_slice_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POLICY_FCFS;
         time_slice_ff <= RESET_TIME_SLICE;
      end else begin
         policy_ff     <= policy_in;
         time_slice_ff <= time_slice_in;
      end
   end

   pds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .policy     (policy_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   pds_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .time_slice (time_slice_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== sim/process_dispatch_scheduler_test.sv =====
module process_dispatch_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pds_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int LIMIT_CYCLES = 500000;
   localparam int SETTLE_CYCLES = 48;
   localparam int RANDOM_ITEMS = 850;
   localparam int CALM_ITEMS = 100;
   localparam int HOLD_AFTER = 80;
   localparam int HOLD_CYCLES = 200;
   localparam logic [1:0] POLICY_NONE = 2'd3;

   typedef struct {
      logic [DATA_W-1:0] id;
      logic [DATA_W-1:0] remaining;
   } job_entry_type;

   class dispatch_scoreboard;
      logic [1:0] policy = POLICY_FCFS;
      logic [DATA_W-1:0] slice = RESET_TIME_SLICE;
      job_entry_type run_queue[$];
      rsp_type pending_results[$];
      int unsigned failures = 0;
      int unsigned results_checked = 0;

      function void set_register(logic addr, logic [15:0] data);
         if (addr == CSR_POLICY) begin
            policy = data[1:0];
         end else begin
            slice = data;
         end
      endfunction

      function void note_request(logic kind, logic [DATA_W-1:0] id, logic [DATA_W-1:0] len);
         rsp_type want;
         job_entry_type head;
         int pick;
         want = '0;
         if (kind == REQ_ENQUEUE) begin
            if (run_queue.size() >= QUEUE_DEPTH) begin
               want.rejected = 1'b1;
            end else begin
               run_queue.push_back('{id: id, remaining: len});
            end
         end else if (run_queue.size() > 0 && policy != POLICY_NONE) begin
            want.dispatched = 1'b1;
            if (policy == POLICY_RR) begin
               head = run_queue.pop_front();
               want.out_id = head.id;
               if (head.remaining > slice) begin
                  want.granted_time = slice;
                  run_queue.push_back('{id: head.id, remaining: head.remaining - slice});
               end else begin
                  want.granted_time = head.remaining;
                  want.completed = 1'b1;
               end
            end else begin
               pick = 0;
               if (policy == POLICY_SJF) begin
                  for (int i = 1; i < run_queue.size(); i++) begin
                     if (run_queue[i].remaining < run_queue[pick].remaining) pick = i;
                  end
               end
               want.out_id = run_queue[pick].id;
               want.granted_time = run_queue[pick].remaining;
               want.completed = 1'b1;
               run_queue.delete(pick);
            end
         end
         want.occupancy = OCC_W'(run_queue.size());
         pending_results.push_back(want);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_checked++;
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            failures++;
            return;
         end
         want = pending_results.pop_front();
         check_field("dispatched", want.dispatched, got.dispatched);
         check_field("out_id", want.out_id, got.out_id);
         check_field("granted_time", want.granted_time, got.granted_time);
         check_field("completed", want.completed, got.completed);
         check_field("rejected", want.rejected, got.rejected);
         check_field("occupancy", want.occupancy, got.occupancy);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_we;
   logic        csr_addr;
   logic [15:0] csr_wdata;

   dispatch_scoreboard sb = new();
   bit idling_on = 1'b1;
   bit held_off = 1'b0;
   int unsigned cycles = 0;

   process_dispatch_scheduler #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("FAIL process_dispatch_scheduler");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_type'(rsp_tdata));
   end

   // result side: short random stalls plus one long hold-off to back up the input
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && sb.results_checked >= HOLD_AFTER && req_tvalid) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic kind, logic [DATA_W-1:0] id, logic [DATA_W-1:0] len);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {len, id};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, id, len);
   endtask

   task automatic send_tick();
      send_item(REQ_TICK, DATA_W'($urandom), DATA_W'($urandom));
   endtask

   // drain all outstanding results, then let any close-up walk finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic addr, logic [15:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(addr, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_length();
      case ($urandom_range(0, 3))
         0, 1: return DATA_W'($urandom_range(0, 12));
         2: return DATA_W'($urandom);
         default: return sb.slice + DATA_W'($urandom_range(0, 2)) - 1'b1;
      endcase
   endfunction

   initial begin
      int sent;
      int phase_len;
      int enq_pct;
      int pol_pick;
      logic [1:0] pol;
      logic [15:0] quantum;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = CSR_POLICY;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset policy and slice, empty tick, field extremes
      send_tick();
      send_item(REQ_ENQUEUE, 16'hFFFF, 16'h0000);
      send_item(REQ_ENQUEUE, 16'h0000, 16'hFFFF);
      send_tick();
      send_tick();
      send_tick();

      // shortest first with a tie on remaining time
      settle();
      write_csr(CSR_POLICY, 16'(POLICY_SJF));
      send_item(REQ_ENQUEUE, 16'd1, 16'd9);
      send_item(REQ_ENQUEUE, 16'd2, 16'd3);
      send_item(REQ_ENQUEUE, 16'd3, 16'd3);
      send_item(REQ_ENQUEUE, 16'd4, 16'h8000);
      send_tick();
      send_tick();

      // unused policy leaves the queue alone
      settle();
      write_csr(CSR_POLICY, 16'(POLICY_NONE));
      send_tick();

      // round robin at reset slice, zero slice, maximum slice
      settle();
      write_csr(CSR_POLICY, 16'(POLICY_RR));
      send_tick();
      settle();
      write_csr(CSR_TIME_SLICE, 16'd0);
      send_tick();
      settle();
      write_csr(CSR_TIME_SLICE, 16'hFFFF);
      send_tick();
      send_tick();
      send_tick();
      send_item(REQ_ENQUEUE, 16'd5, 16'd0);
      send_tick();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         pol_pick = $urandom_range(0, 9);
         pol = (pol_pick < 3) ? POLICY_FCFS : (pol_pick < 6) ? POLICY_SJF :
               (pol_pick < 9) ? POLICY_RR : POLICY_NONE;
         case ($urandom_range(0, 5))
            0: quantum = 16'd0;
            1: quantum = 16'd1;
            2: quantum = 16'hFFFF;
            default: quantum = 16'($urandom_range(1, 20));
         endcase
         write_csr(CSR_POLICY, 16'(pol));
         write_csr(CSR_TIME_SLICE, quantum);
         case ($urandom_range(0, 2))
            0: enq_pct = 25;
            1: enq_pct = 55;
            default: enq_pct = 85;
         endcase
         phase_len = $urandom_range(30, 70);
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
            if ($urandom_range(0, 99) < enq_pct) begin
               send_item(REQ_ENQUEUE, DATA_W'($urandom), pick_length());
            end else begin
               send_tick();
            end
            sent++;
         end
      end

      settle();
      if (sb.failures == 0 && sb.pending_results.size() == 0) begin
         $display("PASS process_dispatch_scheduler");
      end else begin
         $display("FAIL process_dispatch_scheduler");
      end
      $finish;
   end

endmodule
